FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock, off while reset is high
`define SGU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// same-cycle implication
`define SGU_ASSERT_IMPL(label, ante, cons, msg) \
   `SGU_ASSERT(label, ante |-> cons, msg)

// next-cycle implication
`define SGU_ASSERT_NEXT(label, ante, cons, msg) \
   `SGU_ASSERT(label, ante |=> cons, msg)

`endif

FILE: src/sgu_pkg.sv
`default_nettype none

package sgu_pkg;

   localparam int APPROX_TABLE_DEPTH_DFLT = 256;

   localparam int DATA_W     = 16;
   localparam int X_W        = 24;
   localparam int DIVIDEND_W = 40;
   localparam int DIVISOR_W  = 53;
   localparam int QUOT_W     = 16;

   localparam logic [63:0] EXP_ONE          = 64'd1 << 30;
   localparam int          EXP_SERIES_TERMS = 24;

   localparam logic [17:0] PI_Q16     = 18'd205887;
   localparam logic [14:0] INV_PI_Q16 = 15'd20861;

   localparam logic [1:0] MODE_LINEAR       = 2'd0;
   localparam logic [1:0] MODE_EXP          = 2'd1;
   localparam logic [1:0] MODE_FAST_SIGMOID = 2'd2;
   localparam logic [1:0] MODE_ARCTAN       = 2'd3;

   localparam logic [1:0] CSR_SHAPE_MODE   = 2'd0;
   localparam logic [1:0] CSR_THRESHOLD    = 2'd1;
   localparam logic [1:0] CSR_WIDTH_SCALE  = 2'd2;
   localparam logic [1:0] CSR_HEIGHT_SCALE = 2'd3;

   localparam logic [15:0] WIDTH_SCALE_RST  = 16'd4096;
   localparam logic [15:0] HEIGHT_SCALE_RST = 16'd1229;

   // {T[k] (31 bits), T[k] - T[k+1] (30 bits)}, T in Q.30
   typedef logic [60:0] exp_entry_type;

   typedef struct packed {
      logic                  use_div;
      logic [DIVIDEND_W-1:0] rem;
      logic [DIVISOR_W-1:0]  divisor;
      logic [QUOT_W-1:0]     quot;
      logic [DATA_W-1:0]     bypass;
   } div_word_type;

   // Q.30 sum of the exp series at the table step
   function automatic logic [63:0] exp_series_sum(input logic [63:0] step);
      logic [63:0] term;
      logic [63:0] sum;
      term = EXP_ONE;
      sum  = EXP_ONE;
      for (int n = 1; n < EXP_SERIES_TERMS; n++) begin
         term = ((term * step) >> 30) / 64'(n);
         sum  = sum + term;
      end
      return sum;
   endfunction

   function automatic exp_entry_type exp_entry(input logic [63:0] ratio, input int idx);
      logic [63:0] cur;
      logic [63:0] nxt;
      cur = EXP_ONE;
      for (int j = 0; j < idx; j++) begin
         cur = (cur * ratio) >> 30;
      end
      nxt = (cur * ratio) >> 30;
      return {cur[30:0], 30'(cur - nxt)};
   endfunction

endpackage

`default_nettype wire

FILE: src/sgu_div.sv
`default_nettype none

// Restoring divider, one quotient bit per stage, elastic valid/ready chain.
module sgu_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  sgu_pkg::div_word_type      in_word,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [sgu_pkg::DATA_W-1:0] out_value
);
   import sgu_pkg::*;

   localparam int STAGES  = QUOT_W;
   localparam int SHIFT_W = DIVISOR_W + QUOT_W;

   logic         v_ff [STAGES];
   div_word_type w_ff [STAGES];
   logic [STAGES:0] rdy;

   always_comb begin
      rdy[STAGES] = out_ready;
      for (int j = STAGES - 1; j >= 0; j--) begin
         rdy[j] = !v_ff[j] || rdy[j+1];
      end
   end

   for (genvar g = 0; g < STAGES; g++) begin : g_stage
      localparam int BIT = STAGES - 1 - g;

      div_word_type        src;
      logic                src_valid;
      logic [SHIFT_W-1:0]  trial;
      logic                fits;
      div_word_type        w_in;

      if (g == 0) begin : g_first
         assign src       = in_word;
         assign src_valid = in_valid;
      end else begin : g_next
         assign src       = w_ff[g-1];
         assign src_valid = v_ff[g-1];
      end

      assign trial = SHIFT_W'(src.divisor) << BIT;
      assign fits  = {(SHIFT_W - DIVIDEND_W)'(0), src.rem} >= trial;

      always_comb begin
         w_in = src;
         if (fits) begin
            w_in.rem       = src.rem - trial[DIVIDEND_W-1:0];
            w_in.quot[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else if (rdy[g]) begin
            v_ff[g] <= src_valid;
         end
         if (rdy[g]) begin
            w_ff[g] <= w_in;
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[STAGES-1];
   assign out_value = w_ff[STAGES-1].use_div ? w_ff[STAGES-1].quot : w_ff[STAGES-1].bypass;

endmodule

`default_nettype wire

FILE: src/surrogate_gradient_unit.sv
`default_nettype none

// Channel  Dir  Handshake            Word
// req      in   req_valid/req_ready  refractory_count, membrane_voltage
// rsp      out  rsp_valid/rsp_ready  grad
// csr      in   csr_write_en         csr_index, csr_write_data
//
// One word per cycle sustained while rsp is not stalled; 5 datapath stages
// plus a 16-stage divider, one quotient bit per stage, shared by the sigmoid
// and arctan shapes. Every stage holds its own valid bit and fills bubbles while
// rsp is stalled. Synchronous reset clears the valids and loads the register
// defaults; the exp table is constant and needs no fill.
module surrogate_gradient_unit #(
   parameter int APPROX_TABLE_DEPTH = sgu_pkg::APPROX_TABLE_DEPTH_DFLT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic        [sgu_pkg::DATA_W-1:0] req_refractory_count,
   input  logic signed [sgu_pkg::DATA_W-1:0] req_membrane_voltage,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic        [sgu_pkg::DATA_W-1:0] rsp_grad,
   input  logic                              csr_write_en,
   input  logic        [1:0]                 csr_index,
   input  logic        [sgu_pkg::DATA_W-1:0] csr_write_data
);
   import sgu_pkg::*;

   localparam logic [63:0] EXP_STEP  = (64'd1 << 34) / APPROX_TABLE_DEPTH;
   localparam logic [63:0] EXP_SUM   = exp_series_sum(EXP_STEP);
   localparam logic [63:0] EXP_RATIO = (64'd1 << 60) / EXP_SUM;
   localparam int          IDX_W     = $clog2(APPROX_TABLE_DEPTH);
   localparam int          P_W       = 16 + IDX_W;

   exp_entry_type exp_tab [APPROX_TABLE_DEPTH];

   for (genvar k = 0; k < APPROX_TABLE_DEPTH; k++) begin : g_tab
      localparam exp_entry_type ENT = exp_entry(EXP_RATIO, k);
      assign exp_tab[k] = ENT;
   end

   // configuration
   logic        [1:0]        shape_mode_ff;
   logic signed [DATA_W-1:0] threshold_ff;
   logic        [DATA_W-1:0] beta_ff;
   logic        [DATA_W-1:0] gamma_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_mode_ff <= MODE_LINEAR;
         threshold_ff  <= '0;
         beta_ff       <= WIDTH_SCALE_RST;
         gamma_ff      <= HEIGHT_SCALE_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SHAPE_MODE:   shape_mode_ff <= csr_write_data[1:0];
            CSR_THRESHOLD:    threshold_ff  <= csr_write_data;
            CSR_WIDTH_SCALE:  beta_ff       <= csr_write_data;
            CSR_HEIGHT_SCALE: gamma_ff      <= csr_write_data;
            default: ;
         endcase
      end
   end

   // stage valids and ready chain
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;
   logic div_ready;

   assign rdy5      = !v5_ff || div_ready;
   assign rdy4      = !v4_ff || rdy5;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_ready = rdy1;

   // stage 1: distance from threshold
   logic signed [DATA_W:0]   diff;
   logic        [DATA_W-1:0] d1_in, d1_ff;
   logic                     zero1_ff;

   assign diff  = (DATA_W+1)'(req_membrane_voltage) - (DATA_W+1)'(threshold_ff);
   assign d1_in = diff[DATA_W] ? DATA_W'(-diff) : diff[DATA_W-1:0];

   // stage 2: x = beta * d, Q.12
   logic [31:0]    bx;
   logic [X_W-1:0] x2_ff;
   logic           zero2_ff;

   assign bx = 32'(beta_ff) * 32'(d1_ff);

   // stage 3: per-shape first products and table read
   logic [12:0]         f3;
   logic [28:0]         prod0_in, prod0_ff;
   logic [P_W-1:0]      p3;
   logic [IDX_W-1:0]    idx3;
   exp_entry_type       ent_ff;
   logic [15:0]         t3_ff;
   logic                tail3_ff;
   logic [24:0]         u3;
   logic [48:0]         uu_in, uu_ff;
   logic [41:0]         w42;
   logic [25:0]         w_ff;
   logic [30:0]         gpi_in, gpi_ff;
   logic                zero3_ff;

   assign f3       = (x2_ff < X_W'(4096)) ? 13'(X_W'(4096) - x2_ff) : 13'd0;
   assign prod0_in = 29'(gamma_ff) * 29'(f3);
   assign p3       = P_W'(x2_ff[15:0]) * P_W'(APPROX_TABLE_DEPTH);
   assign idx3     = p3[P_W-1:16];
   assign u3       = 25'(x2_ff) + 25'd4096;
   assign uu_in    = 49'(u3) * 49'(u3);
   assign w42      = 42'(x2_ff) * 42'(PI_Q16);
   assign gpi_in   = 31'(gamma_ff) * 31'(INV_PI_Q16);

   // stage 4: second products, divisor and dividend
   logic [15:0]           res0_ff;
   logic [30:0]           tval_ff;
   logic [45:0]           dt46;
   logic [29:0]           dt_ff;
   logic [51:0]           ww;
   logic [DIVISOR_W-1:0]  den_in, den_ff;
   logic [DIVIDEND_W-1:0] num_in, num_ff;
   logic                  tail4_ff;
   logic                  zero4_ff;

   assign dt46 = 46'(ent_ff[29:0]) * 46'(t3_ff);
   assign ww   = 52'(w_ff) * 52'(w_ff);

   // arctan: ((g/pi << 24) / den) >> 16 folds into (g/pi << 8) / den
   always_comb begin
      if (shape_mode_ff == MODE_ARCTAN) begin
         den_in = DIVISOR_W'(ww) + (DIVISOR_W'(1) << 24);
         num_in = {1'b0, gpi_ff, 8'd0};
      end else begin
         den_in = DIVISOR_W'(uu_ff);
         num_in = {gamma_ff, 24'd0};
      end
   end

   // stage 5: exp interpolation result, divider word
   logic [30:0]  e5;
   logic [46:0]  ge5;
   logic [15:0]  res1;
   div_word_type word_in, word_ff;

   assign e5   = tval_ff - 31'(dt_ff);
   assign ge5  = 47'(gamma_ff) * 47'(e5);
   assign res1 = tail4_ff ? 16'd0 : ge5[45:30];

   // every shape stays at or below gamma, so 16 bits never overflow
   always_comb begin
      word_in.rem     = num_ff;
      word_in.divisor = den_ff;
      word_in.quot    = '0;
      unique case (shape_mode_ff)
         MODE_LINEAR: begin
            word_in.use_div = 1'b0;
            word_in.bypass  = res0_ff;
         end
         MODE_EXP: begin
            word_in.use_div = 1'b0;
            word_in.bypass  = res1;
         end
         MODE_FAST_SIGMOID, MODE_ARCTAN: begin
            word_in.use_div = 1'b1;
            word_in.bypass  = '0;
         end
         default: begin
            word_in.use_div = 1'b0;
            word_in.bypass  = '0;
         end
      endcase
      if (zero4_ff) begin
         word_in.use_div = 1'b0;
         word_in.bypass  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         zero1_ff <= |req_refractory_count;
         d1_ff    <= d1_in;
      end
      if (rdy2) begin
         zero2_ff <= zero1_ff;
         x2_ff    <= bx[31:8];
      end
      if (rdy3) begin
         zero3_ff <= zero2_ff;
         prod0_ff <= prod0_in;
         ent_ff   <= exp_tab[idx3];
         t3_ff    <= p3[15:0];
         tail3_ff <= |x2_ff[X_W-1:16];
         uu_ff    <= uu_in;
         w_ff     <= w42[41:16];
         gpi_ff   <= gpi_in;
      end
      if (rdy4) begin
         zero4_ff <= zero3_ff;
         res0_ff  <= prod0_ff[27:12];
         tval_ff  <= ent_ff[60:30];
         dt_ff    <= dt46[45:16];
         tail4_ff <= tail3_ff;
         den_ff   <= den_in;
         num_ff   <= num_in;
      end
      if (rdy5) begin
         word_ff <= word_in;
      end
   end

   sgu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v5_ff),
      .in_ready  (div_ready),
      .in_word   (word_ff),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_value (rsp_grad)
   );

endmodule

`default_nettype wire

FILE: src/sgu_checker.sv
`default_nettype none

`include "assert_macros.svh"

module sgu_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [sgu_pkg::DATA_W-1:0] rsp_grad,
   input logic                       csr_write_en,
   input logic [1:0]                 csr_index,
   input logic [sgu_pkg::DATA_W-1:0] csr_write_data
);
   import sgu_pkg::*;

   // shadow of gamma, the ceiling of every shape
   logic [DATA_W-1:0] gamma_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff <= HEIGHT_SCALE_RST;
      end else if (csr_write_en && csr_index == CSR_HEIGHT_SCALE) begin
         gamma_ff <= csr_write_data;
      end
   end

   `SGU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp word dropped")
   `SGU_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_grad), "rsp word changed")
   `SGU_ASSERT_IMPL(a_gain_bound, rsp_valid, rsp_grad <= gamma_ff, "gradient above gamma")
   `SGU_ASSERT_IMPL(a_ready_drained, !rsp_valid, req_ready, "req blocked with empty output")

endmodule

bind surrogate_gradient_unit sgu_checker u_checker (.*);

`default_nettype wire
